// ===== rtl/ppgray_pkg.sv =====
// ----------------------------------------------------------------------------
// ppgray_pkg
// Types, constants and helper functions of the packed pixel to grayscale unit.
// ----------------------------------------------------------------------------
package ppgray_pkg;

   typedef logic [7:0]  level_type;
   typedef logic [14:0] luma_sum_type;

   localparam logic [2:0] CsrPaletteMode = 3'd0;
   localparam logic [2:0] CsrRedOffset   = 3'd1;
   localparam logic [2:0] CsrRedLength   = 3'd2;
   localparam logic [2:0] CsrGreenOffset = 3'd3;
   localparam logic [2:0] CsrGreenLength = 3'd4;
   localparam logic [2:0] CsrBlueOffset  = 3'd5;
   localparam logic [2:0] CsrBlueLength  = 3'd6;

   localparam logic       CmdConvert      = 1'b0;
   localparam logic       CmdPaletteWrite = 1'b1;

   localparam logic [1:0] ChanRed   = 2'd0;
   localparam logic [1:0] ChanGreen = 2'd1;
   localparam logic [1:0] ChanBlue  = 2'd2;

   localparam logic [3:0] ComponentBitsMax = 4'd8;

   localparam int WeightRed   = 30;
   localparam int WeightGreen = 59;
   localparam int WeightBlue  = 11;

   // floor(s / 100) equals (s * 5243) >> 19 for every sum up to 25500.
   localparam logic [12:0] RecipMul   = 13'd5243;
   localparam int          RecipShift = 19;

   function automatic logic [3:0] clamp_length(input logic [3:0] len);
      logic [3:0] res;
      res = len;
      if (res > ComponentBitsMax) begin
         res = ComponentBitsMax;
      end
      return res;
   endfunction

   function automatic level_type extract_field(input logic [31:0] pix,
                                               input logic [4:0]  off,
                                               input logic [3:0]  len);
      logic [31:0] shifted;
      logic [8:0]  mask;
      shifted = pix >> off;
      mask    = (9'd1 << len) - 9'd1;
      return shifted[7:0] & mask[7:0];
   endfunction

   // Scales an n-bit field to 16 bits as floor(i * 65535 / (2^n - 1)) and keeps
   // the upper byte. Repeating the field bits gives floor(i * 65536 / (2^n - 1));
   // one is taken off when the fraction left over is below i / (2^n - 1), which
   // is the case when the field rotated by (16 mod n) bits is less than the field.
   function automatic level_type expand_level(input logic [3:0] len,
                                              input level_type  field);
      logic [15:0] rep;
      logic [7:0]  rot;
      logic [15:0] diff;
      rep = '0;
      rot = '0;
      unique case (len)
         4'd1: begin
            rep = {16{field[0]}};
            rot = {7'd0, field[0]};
         end
         4'd2: begin
            rep = {8{field[1:0]}};
            rot = {6'd0, field[1:0]};
         end
         4'd3: begin
            rep = {{5{field[2:0]}}, field[2]};
            rot = {5'd0, field[1:0], field[2]};
         end
         4'd4: begin
            rep = {4{field[3:0]}};
            rot = {4'd0, field[3:0]};
         end
         4'd5: begin
            rep = {{3{field[4:0]}}, field[4]};
            rot = {3'd0, field[3:0], field[4]};
         end
         4'd6: begin
            rep = {{2{field[5:0]}}, field[5:2]};
            rot = {2'd0, field[1:0], field[5:2]};
         end
         4'd7: begin
            rep = {{2{field[6:0]}}, field[6:5]};
            rot = {1'b0, field[4:0], field[6:5]};
         end
         4'd8: begin
            rep = {2{field[7:0]}};
            rot = field;
         end
         default: begin
            rep = '0;
            rot = '0;
         end
      endcase
      diff = rep - 16'(rot < field);
      return diff[15:8];
   endfunction

endpackage

// ===== rtl/packed_pixel_to_grayscale_unit.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_to_grayscale_unit
// Converts packed framebuffer pixels to 8-bit gray levels, with truecolor
// expansion or per-channel palette lookup.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Direction  Carries
//   req_      req_valid / req_stall  in         command, pixel or palette write
//   rsp_      rsp_valid / rsp_stall  out        gray level of a convert request
//   csr_      csr_valid / csr_ready  in         register index and write data
//
// One request is taken every cycle while req_stall is low; a gray level is offered
// once its request has passed from the input stage through the registered
// palette read, the weighted sum and the reciprocal multiply. Palette writes
// retire in the input stage.
// Reset clears the pipeline and the registers; palettes keep their contents.
// While rsp_stall holds the output, empty stages still take requests, and
// req_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module packed_pixel_to_grayscale_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_pixel_word,
   input  logic [1:0]  req_palette_channel,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gray_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   logic       palette_mode_ff;
   logic [4:0] red_offset_ff;
   logic [3:0] red_length_ff;
   logic [4:0] green_offset_ff;
   logic [3:0] green_length_ff;
   logic [4:0] blue_offset_ff;
   logic [3:0] blue_length_ff;

   ppgray_pkg::level_type red_palette   [256];
   ppgray_pkg::level_type green_palette [256];
   ppgray_pkg::level_type blue_palette  [256];

   logic                  s1_valid_ff;
   logic                  s1_command_ff;
   logic [31:0]           s1_pixel_ff;
   logic [1:0]            s1_channel_ff;
   logic [7:0]            s1_index_ff;
   ppgray_pkg::level_type s1_value_ff;

   logic                  s2_valid_ff;
   ppgray_pkg::level_type s2_red_pal_ff;
   ppgray_pkg::level_type s2_green_pal_ff;
   ppgray_pkg::level_type s2_blue_pal_ff;
   ppgray_pkg::level_type s2_red_exp_ff;
   ppgray_pkg::level_type s2_green_exp_ff;
   ppgray_pkg::level_type s2_blue_exp_ff;

   logic                     s3_valid_ff;
   ppgray_pkg::luma_sum_type s3_sum_ff;

   logic                  rsp_valid_ff;
   ppgray_pkg::level_type rsp_gray_ff;

   logic                     free1;
   logic                     free2;
   logic                     free3;
   logic                     free4;
   logic                     s2_valid_in;
   logic [3:0]               red_len;
   logic [3:0]               green_len;
   logic [3:0]               blue_len;
   ppgray_pkg::level_type    red_field;
   ppgray_pkg::level_type    green_field;
   ppgray_pkg::level_type    blue_field;
   ppgray_pkg::level_type    red_lvl;
   ppgray_pkg::level_type    green_lvl;
   ppgray_pkg::level_type    blue_lvl;
   ppgray_pkg::luma_sum_type s3_sum_in;
   logic [27:0]              gray_prod;
   ppgray_pkg::level_type    rsp_gray_in;
   logic                     pal_write;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_mode_ff <= 1'b0;
         red_offset_ff   <= 5'd16;
         red_length_ff   <= 4'd8;
         green_offset_ff <= 5'd8;
         green_length_ff <= 4'd8;
         blue_offset_ff  <= 5'd0;
         blue_length_ff  <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppgray_pkg::CsrPaletteMode: palette_mode_ff <= csr_wdata[0];
            ppgray_pkg::CsrRedOffset:   red_offset_ff   <= csr_wdata;
            ppgray_pkg::CsrRedLength:   red_length_ff   <= csr_wdata[3:0];
            ppgray_pkg::CsrGreenOffset: green_offset_ff <= csr_wdata;
            ppgray_pkg::CsrGreenLength: green_length_ff <= csr_wdata[3:0];
            ppgray_pkg::CsrBlueOffset:  blue_offset_ff  <= csr_wdata;
            ppgray_pkg::CsrBlueLength:  blue_length_ff  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // A palette write leaves the input stage at once; a convert request waits
   // for room in the next stage.
   assign free4     = !rsp_valid_ff || !rsp_stall;
   assign free3     = !s3_valid_ff || free4;
   assign free2     = !s2_valid_ff || free3;
   assign free1     = !s1_valid_ff || (s1_command_ff == ppgray_pkg::CmdPaletteWrite) || free2;
   assign req_stall = !free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (free1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         s1_command_ff <= req_command;
         s1_pixel_ff   <= req_pixel_word;
         s1_channel_ff <= req_palette_channel;
         s1_index_ff   <= req_palette_index;
         s1_value_ff   <= req_palette_value[15:8];
      end
   end

   assign pal_write = s1_valid_ff && (s1_command_ff == ppgray_pkg::CmdPaletteWrite);

   always_comb begin
      red_len     = ppgray_pkg::clamp_length(red_length_ff);
      green_len   = ppgray_pkg::clamp_length(green_length_ff);
      blue_len    = ppgray_pkg::clamp_length(blue_length_ff);
      red_field   = ppgray_pkg::extract_field(s1_pixel_ff, red_offset_ff, red_len);
      green_field = ppgray_pkg::extract_field(s1_pixel_ff, green_offset_ff, green_len);
      blue_field  = ppgray_pkg::extract_field(s1_pixel_ff, blue_offset_ff, blue_len);
      s2_valid_in = s1_valid_ff && (s1_command_ff == ppgray_pkg::CmdConvert);
   end

   always_ff @(posedge clock) begin
      if (pal_write && (s1_channel_ff == ppgray_pkg::ChanRed)) begin
         red_palette[s1_index_ff] <= s1_value_ff;
      end
      if (pal_write && (s1_channel_ff == ppgray_pkg::ChanGreen)) begin
         green_palette[s1_index_ff] <= s1_value_ff;
      end
      if (pal_write && (s1_channel_ff == ppgray_pkg::ChanBlue)) begin
         blue_palette[s1_index_ff] <= s1_value_ff;
      end
      if (free2) begin
         s2_red_pal_ff   <= red_palette[red_field];
         s2_green_pal_ff <= green_palette[green_field];
         s2_blue_pal_ff  <= blue_palette[blue_field];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (free2) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free2) begin
         s2_red_exp_ff   <= ppgray_pkg::expand_level(red_len, red_field);
         s2_green_exp_ff <= ppgray_pkg::expand_level(green_len, green_field);
         s2_blue_exp_ff  <= ppgray_pkg::expand_level(blue_len, blue_field);
      end
   end

   always_comb begin
      red_lvl   = palette_mode_ff ? s2_red_pal_ff   : s2_red_exp_ff;
      green_lvl = palette_mode_ff ? s2_green_pal_ff : s2_green_exp_ff;
      blue_lvl  = palette_mode_ff ? s2_blue_pal_ff  : s2_blue_exp_ff;
      s3_sum_in = 15'(ppgray_pkg::WeightRed * int'(red_lvl))
                + 15'(ppgray_pkg::WeightGreen * int'(green_lvl))
                + 15'(ppgray_pkg::WeightBlue * int'(blue_lvl));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (free3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (free3) begin
         s3_sum_ff <= s3_sum_in;
      end
   end

   always_comb begin
      gray_prod   = 28'(s3_sum_ff) * 28'(ppgray_pkg::RecipMul);
      rsp_gray_in = gray_prod[ppgray_pkg::RecipShift +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (free4) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (free4) begin
         rsp_gray_ff <= rsp_gray_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = rsp_gray_ff;

endmodule

// ===== verif/packed_pixel_to_grayscale_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_pixel_to_grayscale_unit_tb
// Drives pixel and palette requests through the grayscale unit under a range
// of field layouts, truecolor and palette modes, and random flow control. Every
// gray level is checked against a directed value or an in-bench predictor.
// ----------------------------------------------------------------------------
module packed_pixel_to_grayscale_unit_tb;

   localparam logic [1:0] ChanUnused   = 2'd3;
   localparam int         DrainCycles  = 8;
   localparam int         IdleLimit    = 2000;
   localparam int         PhaseLength  = 110;

   typedef enum logic { RowRequest, RowRegister } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  command;
      logic [31:0]           pixel;
      logic [1:0]            channel;
      logic [7:0]            index;
      logic [15:0]           value;
      bit                    has_gray;
      ppgray_pkg::level_type gray;
      logic [2:0]            csr_index;
      logic [4:0]            csr_data;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_pixel_word;
   logic [1:0]  req_palette_channel;
   logic [7:0]  req_palette_index;
   logic [15:0] req_palette_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_gray_level;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [4:0]  csr_wdata;

   // Predictor state: a copy of the registers and of the palette contents.
   logic                  cfg_palette_mode;
   logic [4:0]            cfg_offset [3];
   logic [3:0]            cfg_length [3];
   ppgray_pkg::level_type palette_level [3][256];
   bit                    palette_loaded [3][256];

   ppgray_pkg::level_type pending_gray [$];
   stim_row_type          directed_rows [$];
   bit                    row_has_gray;
   ppgray_pkg::level_type row_gray;
   ppgray_pkg::level_type want_gray;
   int                    mismatch_count;
   int                    idle_cycles;
   int                    stall_pct;
   int                    hold_cycles;

   packed_pixel_to_grayscale_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_pixel_word      (req_pixel_word),
      .req_palette_channel (req_palette_channel),
      .req_palette_index   (req_palette_index),
      .req_palette_value   (req_palette_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_gray_level      (rsp_gray_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned channel_length(input int c);
      int unsigned len;
      len = 32'(cfg_length[c]);
      if (len > 32'(ppgray_pkg::ComponentBitsMax)) begin
         len = 32'(ppgray_pkg::ComponentBitsMax);
      end
      return len;
   endfunction

   function automatic ppgray_pkg::level_type field_of(input logic [31:0] pixel, input int c);
      int unsigned mask;
      mask = (32'd1 << channel_length(c)) - 32'd1;
      return 8'((pixel >> cfg_offset[c]) & mask);
   endfunction

   function automatic ppgray_pkg::level_type luma_of_pixel(input logic [31:0] pixel);
      int unsigned level [3];
      int unsigned len;
      int unsigned field;
      int unsigned sum;
      int          c;
      for (c = 0; c < 3; c++) begin
         len   = channel_length(c);
         field = 32'(field_of(pixel, c));
         if (cfg_palette_mode) begin
            level[c] = 32'(palette_level[c][field]);
         end else if (len == 0) begin
            level[c] = 32'd0;
         end else begin
            level[c] = ((field * 32'd65535) / ((32'd1 << len) - 32'd1)) >> 8;
         end
      end
      sum = ppgray_pkg::WeightRed * level[0] + ppgray_pkg::WeightGreen * level[1]
          + ppgray_pkg::WeightBlue * level[2];
      return 8'(sum / 100);
   endfunction

   // Returns the first channel whose palette entry for this pixel was never
   // loaded, or 3 when the pixel may be converted.
   function automatic int missing_channel(input logic [31:0] pixel);
      int c;
      if (cfg_palette_mode) begin
         for (c = 0; c < 3; c++) begin
            if (!palette_loaded[c][field_of(pixel, c)]) begin
               return c;
            end
         end
      end
      return 3;
   endfunction

   function automatic logic [31:0] random_pixel();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_request_row(input logic cmd, input logic [31:0] pixel,
                                           input logic [1:0] channel,
                                           input logic [7:0] index,
                                           input logic [15:0] value,
                                           input bit has_gray,
                                           input ppgray_pkg::level_type gray);
      stim_row_type row;
      row.kind      = RowRequest;
      row.command   = cmd;
      row.pixel     = pixel;
      row.channel   = channel;
      row.index     = index;
      row.value     = value;
      row.has_gray  = has_gray;
      row.gray      = gray;
      row.csr_index = '0;
      row.csr_data  = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_register_row(input logic [2:0] index, input logic [4:0] data);
      stim_row_type row;
      row.kind      = RowRegister;
      row.command   = ppgray_pkg::CmdConvert;
      row.pixel     = '0;
      row.channel   = '0;
      row.index     = '0;
      row.value     = '0;
      row.has_gray  = 1'b0;
      row.gray      = '0;
      row.csr_index = index;
      row.csr_data  = data;
      directed_rows.push_back(row);
   endfunction

   task automatic send_request(input logic cmd, input logic [31:0] pixel,
                               input logic [1:0] channel, input logic [7:0] index,
                               input logic [15:0] value, input bit has_gray,
                               input ppgray_pkg::level_type gray);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_pixel_word      <= pixel;
      req_palette_channel <= channel;
      req_palette_index   <= index;
      req_palette_value   <= value;
      row_has_gray        <= has_gray;
      row_gray            <= gray;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_palette_write(input logic [1:0] channel, input logic [7:0] index,
                                     input logic [15:0] value);
      if (channel != ChanUnused) begin
         palette_loaded[channel][index] = 1'b1;
      end
      send_request(ppgray_pkg::CmdPaletteWrite, $urandom, channel, index, value, 1'b0, '0);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_gray.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [4:0] data);
      wait_until_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      unique case (index)
         ppgray_pkg::CsrPaletteMode: cfg_palette_mode = data[0];
         ppgray_pkg::CsrRedOffset:   cfg_offset[0]    = data;
         ppgray_pkg::CsrRedLength:   cfg_length[0]    = data[3:0];
         ppgray_pkg::CsrGreenOffset: cfg_offset[1]    = data;
         ppgray_pkg::CsrGreenLength: cfg_length[1]    = data[3:0];
         ppgray_pkg::CsrBlueOffset:  cfg_offset[2]    = data;
         ppgray_pkg::CsrBlueLength:  cfg_length[2]    = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_channels(input logic [4:0] mode,
                                   input logic [4:0] red_off, input logic [4:0] red_len,
                                   input logic [4:0] green_off, input logic [4:0] green_len,
                                   input logic [4:0] blue_off, input logic [4:0] blue_len);
      write_register(ppgray_pkg::CsrPaletteMode, mode);
      write_register(ppgray_pkg::CsrRedOffset, red_off);
      write_register(ppgray_pkg::CsrRedLength, red_len);
      write_register(ppgray_pkg::CsrGreenOffset, green_off);
      write_register(ppgray_pkg::CsrGreenLength, green_len);
      write_register(ppgray_pkg::CsrBlueOffset, blue_off);
      write_register(ppgray_pkg::CsrBlueLength, blue_len);
   endtask

   // In palette mode a pixel is only converted once every entry it selects
   // has been loaded; otherwise a missing entry is written in its place.
   task automatic run_phase(input int count, input int idle_pct);
      logic [31:0] pixel;
      int          n;
      int          tries;
      int          c;
      for (n = 0; n < count; n++) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            pause_sender(1);
         end
         if ($urandom_range(0, 99) < (cfg_palette_mode ? 30 : 12)) begin
            send_palette_write(2'($urandom), 8'($urandom), 16'($urandom));
         end else begin
            pixel = random_pixel();
            for (tries = 0; tries < 8 && missing_channel(pixel) != 3; tries++) begin
               pixel = random_pixel();
            end
            c = missing_channel(pixel);
            if (c == 3) begin
               send_request(ppgray_pkg::CmdConvert, pixel, 2'($urandom), 8'($urandom),
                            16'($urandom), 1'b0, '0);
            end else begin
               send_palette_write(2'(c), field_of(pixel, c), 16'($urandom));
            end
         end
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_gray.size() == 0) begin
               $display("%0t: unexpected gray level, expected none, actual %0d",
                        $time, rsp_gray_level);
               mismatch_count++;
            end else begin
               want_gray = pending_gray.pop_front();
               if (rsp_gray_level !== want_gray) begin
                  $display("%0t: gray level mismatch, expected %0d, actual %0d",
                           $time, want_gray, rsp_gray_level);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == ppgray_pkg::CmdConvert) begin
               pending_gray.push_back(row_has_gray ? row_gray : luma_of_pixel(req_pixel_word));
            end else if (req_palette_channel != ChanUnused) begin
               palette_level[req_palette_channel][req_palette_index] = req_palette_value[15:8];
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
      begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: no progress for %0d cycles", $time, IdleLimit);
         $display("packed_pixel_to_grayscale_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      int r;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = ppgray_pkg::CmdConvert;
      req_pixel_word      = '0;
      req_palette_channel = ppgray_pkg::ChanRed;
      req_palette_index   = '0;
      req_palette_value   = '0;
      csr_valid           = 1'b0;
      csr_index           = ppgray_pkg::CsrPaletteMode;
      csr_wdata           = '0;
      row_has_gray        = 1'b0;
      row_gray            = '0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      stall_pct           = 0;
      hold_cycles         = 0;
      cfg_palette_mode    = 1'b0;
      cfg_offset          = '{5'd16, 5'd8, 5'd0};
      cfg_length          = '{4'd8, 4'd8, 4'd8};
      for (r = 0; r < 256; r++) begin
         palette_loaded[0][r] = 1'b0;
         palette_loaded[1][r] = 1'b0;
         palette_loaded[2][r] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset layout is 8-bit red, green and blue at bits 23:16, 15:8 and 7:0.
      add_request_row(ppgray_pkg::CmdConvert, 32'h0000_0000, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd0);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd255);
      add_request_row(ppgray_pkg::CmdConvert, 32'hFFFF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd255);
      add_request_row(ppgray_pkg::CmdConvert, 32'hFF00_0000, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd0);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_0000, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd76);
      add_request_row(ppgray_pkg::CmdConvert, 32'h0000_FF00, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd150);
      add_request_row(ppgray_pkg::CmdConvert, 32'h0000_00FF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd28);
      add_request_row(ppgray_pkg::CmdConvert, 32'h1234_5678, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanRed, 8'd0, 16'h0000,
                      1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanGreen, 8'd0, 16'h00FF,
                      1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanBlue, 8'd0, 16'h0000,
                      1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanRed, 8'd255, 16'hFFFF,
                      1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanGreen, 8'd255,
                      16'hFF00, 1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ppgray_pkg::ChanBlue, 8'd255,
                      16'hFFFF, 1'b0, 8'd0);
      add_request_row(ppgray_pkg::CmdPaletteWrite, '0, ChanUnused, 8'd0, 16'hFFFF,
                      1'b0, 8'd0);
      add_register_row(ppgray_pkg::CsrRedLength, 5'd0);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd178);
      add_register_row(ppgray_pkg::CsrRedLength, 5'd15);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd255);
      add_request_row(ppgray_pkg::CmdConvert, 32'h0080_0000, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b0, 8'd0);
      add_register_row(ppgray_pkg::CsrPaletteMode, 5'd1);
      add_request_row(ppgray_pkg::CmdConvert, 32'h0000_0000, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd0);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd255);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FF00, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd226);
      add_register_row(ppgray_pkg::CsrRedLength, 5'd0);
      add_request_row(ppgray_pkg::CmdConvert, 32'h00FF_FFFF, ppgray_pkg::ChanRed, 8'd0,
                      16'd0, 1'b1, 8'd178);
      add_register_row(ppgray_pkg::CsrRedLength, 5'd8);
      add_register_row(ppgray_pkg::CsrPaletteMode, 5'd0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowRegister) begin
            write_register(directed_rows[i].csr_index, directed_rows[i].csr_data);
         end else if (directed_rows[i].command == ppgray_pkg::CmdPaletteWrite) begin
            send_palette_write(directed_rows[i].channel, directed_rows[i].index,
                               directed_rows[i].value);
         end else begin
            send_request(ppgray_pkg::CmdConvert, directed_rows[i].pixel,
                         ppgray_pkg::ChanRed, 8'd0, 16'd0,
                         directed_rows[i].has_gray, directed_rows[i].gray);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         wait_until_drained();
         unique case (phase)
            1: program_channels(5'd0, 5'd31, 5'd1, 5'd0, 5'd15, 5'd24, 5'd0);
            2: program_channels({4'($urandom), 1'b0}, 5'($urandom), 5'($urandom),
                                5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
            3: program_channels(5'd1, 5'($urandom), 5'd3, 5'($urandom), 5'd2,
                                5'($urandom), 5'd1);
            4: program_channels(5'd1, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0, 5'd8);
            5: program_channels({4'($urandom), 1'b1}, 5'($urandom), 5'($urandom),
                                5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
            6: program_channels(5'd0, 5'($urandom), 5'($urandom_range(1, 8)),
                                5'($urandom), 5'($urandom_range(1, 8)),
                                5'($urandom), 5'($urandom_range(1, 8)));
            7: program_channels(5'd0, 5'd0, 5'd8, 5'd8, 5'd8, 5'd16, 5'd8);
            default: ;
         endcase
         unique case (phase % 4)
            0: begin
               stall_pct = 0;
               run_phase(PhaseLength, 0);
            end
            1: begin
               stall_pct = 0;
               run_phase(PhaseLength, 71);
            end
            2: begin
               stall_pct = 71;
               run_phase(PhaseLength, 0);
            end
            default: begin
               stall_pct = 29;
               run_phase(PhaseLength, 29);
            end
         endcase
      end

      // The output is held off long enough for the pipeline to fill and
      // push back on the request side.
      wait_until_drained();
      stall_pct   = 0;
      hold_cycles = 80;
      run_phase(40, 0);
      wait_until_drained();

      if (mismatch_count == 0) begin
         $display("packed_pixel_to_grayscale_unit_tb: PASS");
      end else begin
         $display("packed_pixel_to_grayscale_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
